/* rtl/pvag_pkg.sv */
// Shared types, codes and reset values for the phrase voice activity gate.
`timescale 1ns / 1ps

package pvag_pkg;

   // Item codes
   localparam logic [1:0] OP_SAMPLE  = 2'd0;
   localparam logic [1:0] OP_FETCH   = 2'd1;
   localparam logic [1:0] OP_RESTART = 2'd2;

   // Status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_NO_SPEECH = 2'd1;
   localparam logic [1:0] STATUS_TOO_SHORT = 2'd2;
   localparam logic [1:0] STATUS_DROPPED   = 2'd3;

   // Register indexes
   localparam logic [2:0] CSR_START_THRESHOLD     = 3'd0;
   localparam logic [2:0] CSR_STOP_THRESHOLD      = 3'd1;
   localparam logic [2:0] CSR_START_RUN_FRAMES    = 3'd2;
   localparam logic [2:0] CSR_STOP_SILENCE_FRAMES = 3'd3;
   localparam logic [2:0] CSR_MIN_HOLD_BYTES      = 3'd4;
   localparam logic [2:0] CSR_MIN_PHRASE_BYTES    = 3'd5;
   localparam logic [2:0] CSR_MAX_FRAMES          = 3'd6;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;

   // Register reset values
   localparam logic [14:0] START_THRESHOLD_RST     = 15'd1200;
   localparam logic [14:0] STOP_THRESHOLD_RST      = 15'd780;
   localparam logic [3:0]  START_RUN_FRAMES_RST    = 4'd2;
   localparam logic [7:0]  STOP_SILENCE_FRAMES_RST = 8'd16;
   localparam logic [23:0] MIN_HOLD_BYTES_RST      = 24'd32000;
   localparam logic [23:0] MIN_PHRASE_BYTES_RST    = 24'd24000;
   localparam logic [15:0] MAX_FRAMES_RST          = 16'd250;

   // Saturation limits
   localparam logic [14:0] PEAK_MAX    = 15'h7FFF;
   localparam logic [3:0]  SPEECH_MAX  = 4'hF;
   localparam logic [7:0]  SILENCE_MAX = 8'hFF;
   localparam logic [15:0] FRAMES_MAX  = 16'hFFFF;
   localparam logic [23:0] BYTES_MAX   = 24'hFFFFFF;

   typedef struct packed {
      logic [1:0]         op;
      logic signed [15:0] sample;
      logic               frame_end;
   } req_type;

   typedef struct packed {
      logic               out_valid;
      logic signed [15:0] out_sample;
      logic               replay_last;
      logic               started;
      logic               finished;
      logic [1:0]         status;
      logic [23:0]        total_bytes;
      logic [14:0]        frame_peak;
   } rsp_type;

   typedef struct packed {
      logic [14:0] start_threshold;
      logic [14:0] stop_threshold;
      logic [3:0]  start_run_frames;
      logic [7:0]  stop_silence_frames;
      logic [23:0] min_hold_bytes;
      logic [23:0] min_phrase_bytes;
      logic [15:0] max_frames;
   } cfg_type;

   // Result in flight: sample comes from the pre-roll RAM when use_ram is set
   typedef struct packed {
      rsp_type rsp;
      logic    use_ram;
   } stage_type;

endpackage

/* rtl/pvag_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module pvag_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 6144
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read; hold data when idle
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/pvag_csr.sv */
// Configuration registers of the phrase voice activity gate.
`timescale 1ns / 1ps

module pvag_csr import pvag_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output cfg_type                cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode the write into the addressed field
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_START_THRESHOLD:     cfg_in.start_threshold     = csr_wdata[14:0];
            CSR_STOP_THRESHOLD:      cfg_in.stop_threshold      = csr_wdata[14:0];
            CSR_START_RUN_FRAMES:    cfg_in.start_run_frames    = csr_wdata[3:0];
            CSR_STOP_SILENCE_FRAMES: cfg_in.stop_silence_frames = csr_wdata[7:0];
            CSR_MIN_HOLD_BYTES:      cfg_in.min_hold_bytes      = csr_wdata[23:0];
            CSR_MIN_PHRASE_BYTES:    cfg_in.min_phrase_bytes    = csr_wdata[23:0];
            CSR_MAX_FRAMES:          cfg_in.max_frames          = csr_wdata[15:0];
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_threshold     <= START_THRESHOLD_RST;
         cfg_ff.stop_threshold      <= STOP_THRESHOLD_RST;
         cfg_ff.start_run_frames    <= START_RUN_FRAMES_RST;
         cfg_ff.stop_silence_frames <= STOP_SILENCE_FRAMES_RST;
         cfg_ff.min_hold_bytes      <= MIN_HOLD_BYTES_RST;
         cfg_ff.min_phrase_bytes    <= MIN_PHRASE_BYTES_RST;
         cfg_ff.max_frames          <= MAX_FRAMES_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* rtl/pvag_ctrl.sv */
// Session control: frame tracking, pre-roll ring bookkeeping and replay walk.
`timescale 1ns / 1ps

module pvag_ctrl import pvag_pkg::*; #(
   parameter int PREROLL_SLOTS = 12,
   parameter int FRAME_SAMPLES = 512,
   localparam int SLOT_W = (PREROLL_SLOTS > 1) ? $clog2(PREROLL_SLOTS) : 1,
   localparam int OFF_W  = $clog2(FRAME_SAMPLES + 1),
   localparam int DEPTH  = PREROLL_SLOTS * FRAME_SAMPLES,
   localparam int ADDR_W = $clog2(DEPTH),
   localparam int RING_W = $clog2(DEPTH + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  req_type           req,
   input  cfg_type           cfg,
   output stage_type         item,
   output logic              ram_we,
   output logic [ADDR_W-1:0] ram_waddr,
   output logic [15:0]       ram_wdata,
   output logic              ram_re,
   output logic [ADDR_W-1:0] ram_raddr
);

   // Control state
   logic [SLOT_W-1:0]        ws_ff, ws_in;
   logic [OFF_W-1:0]         wo_ff, wo_in;
   logic [14:0]              peak_ff, peak_in;
   logic [3:0]               speech_ff, speech_in;
   logic [7:0]               silence_ff, silence_in;
   logic                     active_ff, active_in;
   logic                     done_ff, done_in;
   logic [23:0]              bytes_ff, bytes_in;
   logic [15:0]              frames_ff, frames_in;
   logic [SLOT_W-1:0]        rs_ff, rs_in;
   logic [OFF_W-1:0]         ro_ff, ro_in;
   logic [PREROLL_SLOTS-1:0] mask_ff, mask_in;
   logic [RING_W-1:0]        ring_ff, ring_in;
   logic [OFF_W-1:0]         len_ff [PREROLL_SLOTS];
   logic                     len_we;

   // Slot search
   logic [SLOT_W-1:0]        ws_next;
   logic [SLOT_W-1:0]        rs_plus1;
   logic [PREROLL_SLOTS-1:0] mask_fill;
   logic [PREROLL_SLOTS-1:0] mask_drain;
   logic [SLOT_W-1:0]        srch_base;
   logic [PREROLL_SLOTS-1:0] srch_mask;
   logic                     srch_found;
   logic [SLOT_W-1:0]        srch_idx;

   logic pending;

   assign pending = active_ff && (|mask_ff);

   // Ring neighbors and masks for the two search uses
   assign ws_next  = (int'(ws_ff) + 1 >= PREROLL_SLOTS) ? '0 : ws_ff + 1'b1;
   assign rs_plus1 = (int'(rs_ff) + 1 >= PREROLL_SLOTS) ? '0 : rs_ff + 1'b1;
   assign mask_fill  = mask_ff | (PREROLL_SLOTS'(1) << ws_ff);
   assign mask_drain = mask_ff & ~(PREROLL_SLOTS'(1) << rs_ff);
   assign srch_base = (req.op == OP_FETCH) ? rs_plus1 : ws_next;
   assign srch_mask = (req.op == OP_FETCH) ? mask_drain : mask_fill;

   // Find the nearest filled slot at or after the base, going round the ring
   always_comb begin
      int                cand_i;
      logic [SLOT_W-1:0] cand;
      srch_found = 1'b0;
      srch_idx   = srch_base;
      for (int k = PREROLL_SLOTS - 1; k >= 0; k--) begin
         cand_i = int'(srch_base) + k;
         if (cand_i >= PREROLL_SLOTS) begin
            cand_i = cand_i - PREROLL_SLOTS;
         end
         cand = SLOT_W'(cand_i);
         if (srch_mask[cand]) begin
            srch_found = 1'b1;
            srch_idx   = cand;
         end
      end
   end

   // Next state and result of the item at the input
   always_comb begin
      logic [15:0]       neg;
      logic [15:0]       mag16;
      logic [14:0]       mag;
      logic [14:0]       peak;
      logic [OFF_W-1:0]  wo1;
      logic [OFF_W-1:0]  ro1;
      logic              close;
      logic              dropped;
      logic              stop;
      logic [15:0]       frames_new;
      logic [3:0]        speech_new;
      logic [7:0]        silence_new;
      logic [RING_W-1:0] ring_new;
      logic [RING_W-1:0] old_len;
      logic [24:0]       sum;
      logic [23:0]       bytes_tmp;

      ws_in      = ws_ff;
      wo_in      = wo_ff;
      peak_in    = peak_ff;
      speech_in  = speech_ff;
      silence_in = silence_ff;
      active_in  = active_ff;
      done_in    = done_ff;
      frames_in  = frames_ff;
      rs_in      = rs_ff;
      ro_in      = ro_ff;
      mask_in    = mask_ff;
      ring_in    = ring_ff;
      len_we     = 1'b0;
      bytes_tmp  = bytes_ff;

      item      = '0;
      ram_we    = 1'b0;
      ram_re    = 1'b0;
      ram_wdata = req.sample;
      ram_waddr = ADDR_W'(ADDR_W'(ws_ff) * ADDR_W'(FRAME_SAMPLES)) + ADDR_W'(wo_ff);
      ram_raddr = ADDR_W'(ADDR_W'(rs_ff) * ADDR_W'(FRAME_SAMPLES)) + ADDR_W'(ro_ff);

      neg         = ~req.sample + 16'd1;
      mag16       = req.sample[15] ? neg : req.sample;
      mag         = mag16[15] ? PEAK_MAX : mag16[14:0];
      peak        = (mag > peak_ff) ? mag : peak_ff;
      wo1         = wo_ff + 1'b1;
      ro1         = ro_ff + 1'b1;
      close       = req.frame_end || (int'(wo1) >= FRAME_SAMPLES);
      dropped     = 1'b0;
      stop        = 1'b0;
      frames_new  = (frames_ff != FRAMES_MAX) ? frames_ff + 16'd1 : frames_ff;
      speech_new  = '0;
      silence_new = '0;
      old_len     = mask_ff[ws_ff] ? RING_W'(len_ff[ws_ff]) : '0;
      ring_new    = ring_ff - old_len + RING_W'(wo1);
      sum         = '0;

      case (req.op)
         OP_RESTART: begin
            ws_in      = '0;
            wo_in      = '0;
            peak_in    = '0;
            speech_in  = '0;
            silence_in = '0;
            active_in  = 1'b0;
            done_in    = 1'b0;
            frames_in  = '0;
            rs_in      = '0;
            ro_in      = '0;
            mask_in    = '0;
            ring_in    = '0;
            bytes_tmp  = '0;
         end
         OP_FETCH: begin
            // Read the next replay sample on the transfer only, so the read
            // data hold while the result waits; advance to the next filled slot
            if (pending) begin
               ram_re             = accept;
               item.use_ram       = 1'b1;
               item.rsp.out_valid = 1'b1;
               if (ro1 >= len_ff[rs_ff]) begin
                  mask_in = mask_drain;
                  ro_in   = '0;
                  if (srch_found) begin
                     rs_in = srch_idx;
                  end else begin
                     item.rsp.replay_last = 1'b1;
                  end
               end else begin
                  ro_in = ro1;
               end
            end
         end
         OP_SAMPLE: begin
            if (!done_ff) begin
               // Store, drop or pass the sample
               if (!active_ff) begin
                  ram_we = accept;
               end else if (|mask_ff) begin
                  dropped = 1'b1;
               end else begin
                  item.rsp.out_valid  = 1'b1;
                  item.rsp.out_sample = req.sample;
                  sum = {1'b0, bytes_ff} + 25'd2;
                  bytes_tmp = sum[24] ? BYTES_MAX : sum[23:0];
               end

               if (close) begin
                  item.rsp.frame_peak = peak;
                  peak_in   = '0;
                  frames_in = frames_new;
                  wo_in     = '0;
                  if (!active_ff) begin
                     // Close a pre-roll slot and check for speech start
                     len_we  = 1'b1;
                     mask_in = mask_fill;
                     ws_in   = ws_next;
                     ring_in = ring_new;
                     if (peak >= cfg.start_threshold) begin
                        speech_new = (speech_ff == SPEECH_MAX) ? speech_ff
                                                               : speech_ff + 4'd1;
                     end
                     speech_in = speech_new;
                     if (speech_new >= cfg.start_run_frames) begin
                        active_in  = 1'b1;
                        silence_in = '0;
                        item.rsp.started = 1'b1;
                        sum = {1'b0, bytes_tmp} + 25'({ring_new, 1'b0});
                        bytes_tmp = sum[24] ? BYTES_MAX : sum[23:0];
                        rs_in = srch_idx;
                        ro_in = '0;
                     end
                  end else begin
                     // Count silent frames once the hold amount is recorded
                     if (peak >= cfg.stop_threshold || bytes_tmp < cfg.min_hold_bytes) begin
                        silence_in = '0;
                     end else begin
                        silence_new = (silence_ff == SILENCE_MAX) ? silence_ff
                                                                  : silence_ff + 8'd1;
                        silence_in  = silence_new;
                        stop        = silence_new >= cfg.stop_silence_frames;
                     end
                  end
                  if (frames_new >= cfg.max_frames) begin
                     stop = 1'b1;
                  end
                  if (stop) begin
                     done_in = 1'b1;
                     item.rsp.finished = 1'b1;
                  end
               end else begin
                  wo_in   = wo1;
                  peak_in = peak;
               end
            end
         end
         default: begin
            item = '0;
         end
      endcase

      // Final status wins over a dropped sample
      if (item.rsp.finished) begin
         if (!active_in) begin
            item.rsp.status = STATUS_NO_SPEECH;
         end else if (bytes_tmp < cfg.min_phrase_bytes) begin
            item.rsp.status = STATUS_TOO_SHORT;
         end else begin
            item.rsp.status = STATUS_OK;
         end
      end else if (dropped) begin
         item.rsp.status = STATUS_DROPPED;
      end

      bytes_in = bytes_tmp;
      item.rsp.total_bytes = bytes_tmp;
   end

   // Advance control state on each transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         ws_ff      <= '0;
         wo_ff      <= '0;
         peak_ff    <= '0;
         speech_ff  <= '0;
         silence_ff <= '0;
         active_ff  <= 1'b0;
         done_ff    <= 1'b0;
         bytes_ff   <= '0;
         frames_ff  <= '0;
         rs_ff      <= '0;
         ro_ff      <= '0;
         mask_ff    <= '0;
         ring_ff    <= '0;
      end else if (accept) begin
         ws_ff      <= ws_in;
         wo_ff      <= wo_in;
         peak_ff    <= peak_in;
         speech_ff  <= speech_in;
         silence_ff <= silence_in;
         active_ff  <= active_in;
         done_ff    <= done_in;
         bytes_ff   <= bytes_in;
         frames_ff  <= frames_in;
         rs_ff      <= rs_in;
         ro_ff      <= ro_in;
         mask_ff    <= mask_in;
         ring_ff    <= ring_in;
      end
   end

   // Slot lengths; a slot whose mask bit is clear reads as empty
   always_ff @(posedge clock) begin
      if (accept && len_we) begin
         len_ff[ws_ff] <= wo_ff + 1'b1;
      end
   end

`ifndef SYNTHESIS
   // Pre-roll is only written while waiting for speech
   assert property (@(posedge clock) disable iff (reset) ram_we |-> !active_ff)
      else $error("pre-roll write while phrase active");
   // Store and replay never share a cycle
   assert property (@(posedge clock) disable iff (reset) !(ram_we && ram_re))
      else $error("pre-roll read and write in one cycle");
   // Open frame never reaches the frame size
   assert property (@(posedge clock) disable iff (reset) int'(wo_ff) < FRAME_SAMPLES)
      else $error("frame offset overflow");
   // A start transfer leaves the phrase active with replay pending
   assert property (@(posedge clock) disable iff (reset)
      (accept && item.rsp.started) |=> (active_ff && (|mask_ff)))
      else $error("phrase start without pending replay");
`endif

endmodule

/* rtl/pvag_out.sv */
// Result pipeline: one stage waiting on the RAM read, then the output register.
`timescale 1ns / 1ps

module pvag_out import pvag_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        accept,
   input  stage_type   item,
   input  logic [15:0] ram_rdata,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_payload
);

   logic      s1_valid_ff, s1_valid_in;
   stage_type s1_ff;
   logic      rsp_valid_ff, rsp_valid_in;
   rsp_type   rsp_ff;
   rsp_type   merged;
   logic      s1_move;

   // Move the stage forward when the output register is free or drains
   assign s1_move   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_move;
   assign accept    = req_valid && req_ready;

   // Merge the RAM read data into the result
   always_comb begin
      merged = s1_ff.rsp;
      if (s1_ff.use_ram) begin
         merged.out_sample = ram_rdata;
      end
   end

   always_comb begin
      s1_valid_in  = accept || (s1_valid_ff && !s1_move);
      rsp_valid_in = s1_move || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold payloads until the next transfer
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= item;
      end
      if (s1_move) begin
         rsp_ff <= merged;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

/* rtl/phrase_voice_activity_gate.sv */
// Each item's result passes the stage register and then the output register.
// Throughput: one item per cycle while results are taken; each item is one
// control-register read-modify-write plus at most one pre-roll RAM access.
// Reset: synchronous; clears session state, the result pipeline and loads the
// register defaults. Pre-roll RAM is not cleared; only written entries replay.
`timescale 1ns / 1ps

module phrase_voice_activity_gate import pvag_pkg::*; #(
   parameter int PREROLL_SLOTS = 12,
   parameter int FRAME_SAMPLES = 512
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_payload,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int DEPTH  = PREROLL_SLOTS * FRAME_SAMPLES;
   localparam int ADDR_W = $clog2(DEPTH);

   cfg_type           cfg;
   stage_type         item;
   logic              accept;
   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr;
   logic [15:0]       ram_wdata;
   logic              ram_re;
   logic [ADDR_W-1:0] ram_raddr;
   logic [15:0]       ram_rdata;

   pvag_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   pvag_ctrl #(
      .PREROLL_SLOTS (PREROLL_SLOTS),
      .FRAME_SAMPLES (FRAME_SAMPLES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req       (req_payload),
      .cfg       (cfg),
      .item      (item),
      .ram_we    (ram_we),
      .ram_waddr (ram_waddr),
      .ram_wdata (ram_wdata),
      .ram_re    (ram_re),
      .ram_raddr (ram_raddr)
   );

   pvag_ram #(
      .WIDTH (16),
      .DEPTH (DEPTH)
   ) u_preroll_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   pvag_out u_out (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .accept      (accept),
      .item        (item),
      .ram_rdata   (ram_rdata),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

/* bench/phrase_voice_activity_gate_test.sv */
// Self-checking testbench for the phrase voice activity gate.
`timescale 1ns / 1ps

module phrase_voice_activity_gate_test;
   import pvag_pkg::*;

   localparam int RING_SLOTS  = 12;
   localparam int FRAME_LEN   = 512;
   localparam int CYCLE_LIMIT = 200_000;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_type                req_payload = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_type                rsp_payload;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // Stimulus and scoreboard
   req_type     items_pending[$];
   rsp_type     responses_due[$];
   int          queued_count = 0;
   int          mismatches = 0;
   int unsigned cycles = 0;
   bit          calm = 1'b0;

   // Gate state as the predictor sees it
   cfg_type     cfg;
   logic [15:0] ring_mem [RING_SLOTS*FRAME_LEN];
   logic [9:0]  slot_len [RING_SLOTS];
   logic [3:0]  wr_slot;
   logic [9:0]  wr_offset;
   logic [14:0] peak_acc;
   logic [3:0]  speech_count;
   logic [7:0]  silence_count;
   logic        in_phrase;
   logic        session_over;
   logic [23:0] bytes_rec;
   logic [15:0] frames_seen;
   logic [3:0]  rp_slot;
   logic [9:0]  rp_offset;
   logic [3:0]  rp_left;

   phrase_voice_activity_gate #(
      .PREROLL_SLOTS(RING_SLOTS),
      .FRAME_SAMPLES(FRAME_LEN)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_payload(rsp_payload),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   function automatic void clear_session();
      foreach (slot_len[i]) slot_len[i] = '0;
      wr_slot = '0;
      wr_offset = '0;
      peak_acc = '0;
      speech_count = '0;
      silence_count = '0;
      in_phrase = 1'b0;
      session_over = 1'b0;
      bytes_rec = '0;
      frames_seen = '0;
      rp_slot = '0;
      rp_offset = '0;
      rp_left = '0;
   endfunction

   function automatic logic [23:0] add_bytes(input logic [23:0] acc, input int unsigned n);
      longint s;
      s = longint'(acc) + n;
      return (s > BYTES_MAX) ? BYTES_MAX : s[23:0];
   endfunction

   function automatic logic [3:0] next_slot(input logic [3:0] s);
      return 4'((s + 1) % RING_SLOTS);
   endfunction

   // Advance the replay pointer past slots that hold nothing
   function automatic void skip_empty_slots();
      while (rp_left != 0 && slot_len[rp_slot] == 0) begin
         rp_slot = next_slot(rp_slot);
         rp_left--;
      end
   endfunction

   // Work out the result of one item and update the gate state
   function automatic rsp_type gate_response(input req_type item);
      rsp_type     r;
      logic [16:0] mag;
      logic [14:0] peak;
      logic        dropped;
      logic        stop_now;
      int unsigned sum;
      r = '0;
      dropped = 1'b0;
      stop_now = 1'b0;
      case (item.op)
         OP_RESTART: clear_session();
         OP_FETCH: begin
            if (rp_left != 0) begin
               r.out_valid = 1'b1;
               r.out_sample = ring_mem[rp_slot * FRAME_LEN + rp_offset];
               rp_offset++;
               if (rp_offset >= slot_len[rp_slot]) begin
                  slot_len[rp_slot] = '0;
                  rp_slot = next_slot(rp_slot);
                  rp_left--;
                  rp_offset = '0;
                  skip_empty_slots();
                  r.replay_last = (rp_left == 0);
               end
            end
         end
         OP_SAMPLE: begin
            if (!session_over) begin
               mag = item.sample[15] ? 17'h10000 - {1'b0, item.sample} : {1'b0, item.sample};
               if (mag > 17'h7FFF) mag = 17'h7FFF;
               if (mag[14:0] > peak_acc) peak_acc = mag[14:0];

               // Store while waiting, drop while replay is pending, else pass through
               if (!in_phrase) begin
                  ring_mem[wr_slot * FRAME_LEN + wr_offset] = item.sample;
               end else if (rp_left != 0) begin
                  dropped = 1'b1;
               end else begin
                  r.out_valid = 1'b1;
                  r.out_sample = item.sample;
                  bytes_rec = add_bytes(bytes_rec, 2);
               end
               wr_offset++;

               // Frame close: marked end or a full frame
               if (item.frame_end || wr_offset >= FRAME_LEN) begin
                  peak = peak_acc;
                  peak_acc = '0;
                  r.frame_peak = peak;
                  if (frames_seen != FRAMES_MAX) frames_seen++;
                  if (!in_phrase) begin
                     slot_len[wr_slot] = wr_offset;
                     wr_slot = next_slot(wr_slot);
                     wr_offset = '0;
                     if (peak >= cfg.start_threshold) begin
                        if (speech_count != SPEECH_MAX) speech_count++;
                     end else begin
                        speech_count = '0;
                     end
                     if (speech_count >= cfg.start_run_frames) begin
                        in_phrase = 1'b1;
                        silence_count = '0;
                        r.started = 1'b1;
                        sum = 0;
                        foreach (slot_len[i]) sum += slot_len[i];
                        bytes_rec = add_bytes(bytes_rec, 2 * sum);
                        rp_slot = wr_slot;
                        rp_offset = '0;
                        rp_left = 4'(RING_SLOTS);
                        skip_empty_slots();
                     end
                  end else begin
                     wr_offset = '0;
                     if (peak >= cfg.stop_threshold || bytes_rec < cfg.min_hold_bytes) begin
                        silence_count = '0;
                     end else begin
                        if (silence_count != SILENCE_MAX) silence_count++;
                        if (silence_count >= cfg.stop_silence_frames) stop_now = 1'b1;
                     end
                  end
                  if (frames_seen >= cfg.max_frames) stop_now = 1'b1;
                  if (stop_now) begin
                     session_over = 1'b1;
                     r.finished = 1'b1;
                  end
               end
            end
         end
         default: ;
      endcase

      // Final status wins over a dropped sample
      if (r.finished) begin
         if (!in_phrase) r.status = STATUS_NO_SPEECH;
         else if (bytes_rec < cfg.min_phrase_bytes) r.status = STATUS_TOO_SHORT;
         else r.status = STATUS_OK;
      end else if (dropped) begin
         r.status = STATUS_DROPPED;
      end
      r.total_bytes = bytes_rec;
      return r;
   endfunction

   // ---------------------------------------------------------------- driver

   // Predict on each input transfer, then hold or refill the request
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) responses_due.push_back(gate_response(req_payload));
         if (!req_valid || req_ready) begin
            if (items_pending.size() != 0 && (calm || $urandom_range(99) >= 9)) begin
               req_valid <= 1'b1;
               req_payload <= items_pending.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- monitor

   task automatic check_field(input string name, input logic [23:0] want,
                              input logic [23:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatches++;
      end
   endtask

   // Compare each result transfer with the oldest prediction
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (responses_due.size() == 0) begin
               $error("result transfer with no prediction pending");
               mismatches++;
            end else begin
               want = responses_due.pop_front();
               check_field("out_valid", 24'(want.out_valid), 24'(rsp_payload.out_valid));
               check_field("out_sample", 24'(want.out_sample), 24'(rsp_payload.out_sample));
               check_field("replay_last", 24'(want.replay_last),
                           24'(rsp_payload.replay_last));
               check_field("started", 24'(want.started), 24'(rsp_payload.started));
               check_field("finished", 24'(want.finished), 24'(rsp_payload.finished));
               check_field("status", 24'(want.status), 24'(rsp_payload.status));
               check_field("total_bytes", want.total_bytes, rsp_payload.total_bytes);
               check_field("frame_peak", 24'(want.frame_peak), 24'(rsp_payload.frame_peak));
            end
         end
         rsp_ready <= calm || $urandom_range(99) >= 9;
      end
   end

   // Bound the run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("phrase_voice_activity_gate verification failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------- stimulus

   function automatic void queue_item(input logic [1:0] op, input logic [15:0] sample,
                                      input logic frame_end);
      req_type t;
      t.op = op;
      t.sample = sample;
      t.frame_end = frame_end;
      items_pending.push_back(t);
      if (op != OP_UNUSED) queued_count++;
   endfunction

   // One frame of len samples within +/-lvl, reaching lvl at one random place
   function automatic void queue_frame(input int len, input int lvl, input bit close);
      int loud_at;
      int v;
      loud_at = $urandom_range(len - 1);
      for (int j = 0; j < len; j++) begin
         if (j == loud_at) begin
            if ($urandom_range(1)) v = lvl;
            else v = (lvl == 32767 && $urandom_range(1)) ? -32768 : -lvl;
         end else begin
            v = int'($urandom_range(2 * lvl)) - lvl;
         end
         queue_item(OP_SAMPLE, 16'(v), close && j == len - 1);
      end
   endfunction

   // Restart, wait in quiet, trigger, drain the pre-roll, record, then some noise
   function automatic void queue_session(input bit overlong);
      int recent[$];
      int len;
      int backlog;
      int quiet_start;
      int quiet_stop;
      quiet_start = (cfg.start_threshold > 0) ? cfg.start_threshold - 1 : 0;
      quiet_stop = (cfg.stop_threshold > 0) ? cfg.stop_threshold - 1 : 0;
      queue_item(OP_RESTART, 16'($urandom), 1'($urandom));
      if (overlong) begin
         queue_frame(FRAME_LEN, quiet_start, 1'b0);
         recent.push_back(FRAME_LEN);
      end
      repeat ($urandom_range(0, 14)) begin
         len = $urandom_range(1, 5);
         queue_frame(len, ($urandom_range(4) == 0) ? cfg.start_threshold : quiet_start, 1'b1);
         recent.push_back(len);
      end
      repeat ((cfg.start_run_frames == 0) ? 1 : cfg.start_run_frames) begin
         len = $urandom_range(1, 5);
         queue_frame(len, cfg.start_threshold, 1'b1);
         recent.push_back(len);
      end
      while (recent.size() > RING_SLOTS) void'(recent.pop_front());

      // Fetch about the whole ring, with a live sample dropped now and then
      backlog = recent.sum() + $urandom_range(0, 2);
      for (int k = 0; k < backlog; k++) begin
         if ($urandom_range(99) < 6) begin
            queue_item(OP_SAMPLE, 16'($urandom), $urandom_range(99) < 30);
         end
         queue_item(OP_FETCH, 16'($urandom), 1'($urandom));
      end

      repeat ($urandom_range(2, 12)) begin
         queue_frame($urandom_range(1, 6),
                     $urandom_range(1) ? cfg.stop_threshold : quiet_stop, 1'b1);
      end
      repeat ($urandom_range(0, 3)) queue_item(2'($urandom), 16'($urandom), 1'($urandom));
   endfunction

   function automatic cfg_type random_cfg();
      cfg_type c;
      c.start_threshold = 15'($urandom_range(32767));
      c.stop_threshold = 15'($urandom_range(32767));
      c.start_run_frames = 4'($urandom_range(1, 4));
      c.stop_silence_frames = 8'($urandom_range(0, 4));
      c.min_hold_bytes = 24'($urandom_range(0, 120));
      c.min_phrase_bytes = 24'($urandom_range(0, 160));
      c.max_frames = 16'($urandom_range(2, 40));
      return c;
   endfunction

   task automatic write_reg(input logic [2:0] idx, input logic [23:0] data);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_START_THRESHOLD:     cfg.start_threshold = data[14:0];
         CSR_STOP_THRESHOLD:      cfg.stop_threshold = data[14:0];
         CSR_START_RUN_FRAMES:    cfg.start_run_frames = data[3:0];
         CSR_STOP_SILENCE_FRAMES: cfg.stop_silence_frames = data[7:0];
         CSR_MIN_HOLD_BYTES:      cfg.min_hold_bytes = data;
         CSR_MIN_PHRASE_BYTES:    cfg.min_phrase_bytes = data;
         CSR_MAX_FRAMES:          cfg.max_frames = data[15:0];
         default: ;
      endcase
   endtask

   // Write every register; unused upper data bits carry junk
   task automatic apply_cfg(input cfg_type c);
      logic [23:0] junk;
      junk = 24'($urandom);
      write_reg(CSR_START_THRESHOLD, {junk[23:15], c.start_threshold});
      write_reg(CSR_STOP_THRESHOLD, {junk[23:15], c.stop_threshold});
      write_reg(CSR_START_RUN_FRAMES, {junk[23:4], c.start_run_frames});
      write_reg(CSR_STOP_SILENCE_FRAMES, {junk[23:8], c.stop_silence_frames});
      write_reg(CSR_MIN_HOLD_BYTES, c.min_hold_bytes);
      write_reg(CSR_MIN_PHRASE_BYTES, c.min_phrase_bytes);
      write_reg(CSR_MAX_FRAMES, {junk[23:16], c.max_frames});
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Wait until every item is transferred and every result is back
   task automatic wait_drained();
      do @(negedge clock);
      while (items_pending.size() != 0 || req_valid || responses_due.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   initial begin
      cfg_type c;
      int budget;
      clear_session();
      cfg = '{START_THRESHOLD_RST, STOP_THRESHOLD_RST, START_RUN_FRAMES_RST,
              STOP_SILENCE_FRAMES_RST, MIN_HOLD_BYTES_RST, MIN_PHRASE_BYTES_RST,
              MAX_FRAMES_RST};
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed, reset registers: ignored op, idle fetch, full-scale peaks, start
      @(negedge clock);
      queue_item(OP_UNUSED, 16'h7FFF, 1'b1);
      queue_item(OP_FETCH, 16'h8000, 1'b0);
      queue_item(OP_SAMPLE, 16'h8000, 1'b1);
      queue_item(OP_SAMPLE, 16'h7FFF, 1'b0);
      queue_item(OP_SAMPLE, 16'hFFFF, 1'b0);
      queue_item(OP_SAMPLE, 16'h0000, 1'b1);
      // live sample lost while replay is pending, then drain and one idle fetch
      queue_item(OP_SAMPLE, 16'd1234, 1'b0);
      repeat (5) queue_item(OP_FETCH, 16'h0000, 1'b0);
      queue_item(OP_SAMPLE, 16'd500, 1'b0);
      queue_item(OP_SAMPLE, -16'sd700, 1'b1);
      queue_item(OP_RESTART, 16'hFFFF, 1'b1);
      queue_item(OP_SAMPLE, 16'h5555, 1'b1);
      queue_item(OP_SAMPLE, 16'hAAAA, 1'b1);
      wait_drained();

      // Directed: drop and finish on the same close, replay after the session ends
      c = '{15'd10, STOP_THRESHOLD_RST, 4'd1, STOP_SILENCE_FRAMES_RST,
            MIN_HOLD_BYTES_RST, MIN_PHRASE_BYTES_RST, 16'd2};
      apply_cfg(c);
      @(negedge clock);
      queue_item(OP_RESTART, 16'h0000, 1'b0);
      queue_item(OP_SAMPLE, 16'd100, 1'b1);
      queue_item(OP_SAMPLE, 16'd5, 1'b1);
      queue_item(OP_FETCH, 16'h0000, 1'b0);
      queue_item(OP_SAMPLE, 16'h7FFF, 1'b1);
      wait_drained();

      // Random sessions under zero, all-ones and random register settings
      for (int p = 0; p < 7; p++) begin
         case (p)
            0:       c = '0;
            1:       c = '1;
            default: c = random_cfg();
         endcase
         apply_cfg(c);
         @(negedge clock);
         calm = (p == 2 || p == 3);
         budget = queued_count + 70;
         if (p == 4) queue_session(1'b1);
         while (queued_count < budget) queue_session(1'b0);
         wait_drained();
      end
      calm = 1'b0;

      repeat (10) @(posedge clock);
      if (mismatches == 0 && responses_due.size() == 0) begin
         $display("phrase_voice_activity_gate verification clean");
      end else begin
         $display("phrase_voice_activity_gate verification failed");
      end
      $finish;
   end

endmodule
